### design/gcs_pkg.sv
// Shared types, codes and constants for the grayscale contrast stretch block.
package gcs_pkg;

    // Pixel and gain widths.
    localparam int PIX_W     = 8;
    localparam int PROD_W    = 2 * PIX_W;
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Largest pixel value, also the dividend of the gain.
    localparam logic [PIX_W-1:0] PIXEL_MAX = '1;

    // Operation carried by each input item.
    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_STRETCH = 1'b1
    } t_opcode;

    // One input item.
    typedef struct packed {
        t_opcode          opcode;
        logic [PIX_W-1:0] pixel;
        logic             first_of_frame;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [PIX_W-1:0] stretched;
        logic             flat_frame;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic measure;
        logic capture;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flat;
        logic gain_ok;
        logic div_last;
    } t_status;

endpackage

### design/gcs_stream_if.sv
// Valid/ready stream channel that carries one payload per transfer.
interface gcs_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

### design/gray_contrast_stretch.sv
// Top level of the grayscale min/max contrast stretch block.
//
// Each frame is presented twice: a measure pass (opcode 0) tracks the least and greatest
// pixel, a first-of-frame flag restarting the tracking, and a stretch pass (opcode 1)
// returns (pixel - least) * floor(255 / (greatest - least)) saturated to 0..255, or 0 with
// flat_frame set when greatest is not above least. A measured pixel gives no result. A
// stretched pixel is first captured, then goes through the 8x8 multiply into the result
// register once that register is free. When the frame is not flat, the first stretched
// pixel after any measure also runs the gain divider, a restoring divider that yields one
// quotient bit a cycle until all 8 gain bits are formed; the gain is then held for the
// rest of the pass. A flat frame never runs the divider. The result register lets the next
// item be accepted while a result waits for its transfer.
module gray_contrast_stretch
    import gcs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    gcs_stream_if.sink   i_pix,
    gcs_stream_if.source o_res
);

    t_cmd      cmd;
    t_status   status;
    t_in_item  in_item;
    t_out_item out_item;
    logic      in_ready;
    logic      out_valid;

    assign in_item = i_pix.payload;

    // Sequencing of transfers, division and result loads.
    gcs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_opcode    (in_item.opcode),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Extremes, gain and stretch arithmetic.
    gcs_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (in_item),
        .o_status (status),
        .o_item   (out_item)
    );

    assign i_pix.ready   = in_ready;
    assign o_res.valid   = out_valid;
    assign o_res.payload = out_item;

endmodule

### design/gcs_datapath.sv
// Datapath: extreme tracking, serial gain divider, stretch multiplier and result register.
module gcs_datapath
    import gcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    output t_status   o_status,
    output t_out_item o_item
);

    logic [PIX_W-1:0]  r_least,   n_least;
    logic [PIX_W-1:0]  r_greatest, n_greatest;
    logic              r_gain_ok, n_gain_ok;
    logic [PIX_W-1:0]  r_gain,    n_gain;
    logic [PIX_W-1:0]  r_rem,     n_rem;
    logic [STEP_W-1:0] r_cnt,     n_cnt;
    logic [PIX_W-1:0]  r_pix,     n_pix;
    t_out_item         r_out,     n_out;

    logic [PIX_W-1:0]  lo_base;
    logic [PIX_W-1:0]  hi_base;
    logic [PIX_W-1:0]  span;
    logic [PIX_W:0]    rem_sh;
    logic [PIX_W:0]    rem_sub;
    logic              rem_ge;
    logic [PIX_W-1:0]  pix_off;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  sat;
    logic              flat;

    // The frame is flat when the greatest pixel is not above the least one.
    assign flat = (r_greatest <= r_least);
    assign span = r_greatest - r_least;

    // Running extremes; a first-of-frame pixel restarts them.
    always_comb begin
        lo_base    = i_item.first_of_frame ? PIXEL_MAX : r_least;
        hi_base    = i_item.first_of_frame ? '0 : r_greatest;
        n_least    = r_least;
        n_greatest = r_greatest;
        if (i_cmd.measure) begin
            n_least    = (i_item.pixel < lo_base) ? i_item.pixel : lo_base;
            n_greatest = (i_item.pixel > hi_base) ? i_item.pixel : hi_base;
        end
    end

    // Restoring division of the all-ones dividend by the span, one quotient bit a cycle.
    always_comb begin
        rem_sh    = {r_rem, 1'b1};
        rem_sub   = rem_sh - {1'b0, span};
        rem_ge    = (rem_sh >= {1'b0, span});
        n_rem     = r_rem;
        n_gain    = r_gain;
        n_cnt     = r_cnt;
        n_gain_ok = r_gain_ok;
        if (i_cmd.div_start) begin
            n_rem  = '0;
            n_gain = '0;
            n_cnt  = '0;
        end else if (i_cmd.div_step) begin
            n_rem  = rem_ge ? rem_sub[PIX_W-1:0] : rem_sh[PIX_W-1:0];
            n_gain = {r_gain[PIX_W-2:0], rem_ge};
            n_cnt  = r_cnt + STEP_W'(1);
            if (o_status.div_last) begin
                n_gain_ok = 1'b1;
            end
        end
        // New extremes make the held gain stale.
        if (i_cmd.measure) begin
            n_gain_ok = 1'b0;
        end
    end

    // Offset of the pixel above the least value, times the gain, saturated.
    always_comb begin
        n_pix   = i_cmd.capture ? i_item.pixel : r_pix;
        pix_off = (r_pix > r_least) ? (r_pix - r_least) : '0;
        prod    = PROD_W'(pix_off) * PROD_W'(r_gain);
        sat     = (|prod[PROD_W-1:PIX_W]) ? PIXEL_MAX : prod[PIX_W-1:0];
        n_out   = r_out;
        if (i_cmd.out_load) begin
            n_out.stretched  = flat ? '0 : sat;
            n_out.flat_frame = flat;
        end
    end

    // Extremes and gain validity are cleared by reset; operands and results are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_least    <= PIXEL_MAX;
            r_greatest <= '0;
            r_gain_ok  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_least    <= n_least;
            r_greatest <= n_greatest;
            r_gain_ok  <= n_gain_ok;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain <= n_gain;
        r_rem  <= n_rem;
        r_pix  <= n_pix;
        r_out  <= n_out;
    end

    assign o_status.flat     = flat;
    assign o_status.gain_ok  = r_gain_ok;
    assign o_status.div_last = (r_cnt == STEP_W'(DIV_STEPS - 1));
    assign o_item            = r_out;

    // A measured pixel always leaves the least value at or below the greatest.
    a_measure_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.measure |=> (r_least <= r_greatest))
        else $error("extremes out of order after a measure");

    // A held gain always belongs to a frame that is not flat.
    a_gain_not_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain_ok |-> !flat)
        else $error("gain marked valid for a flat frame");

    // The divider never runs while the extremes change.
    a_div_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> !i_cmd.measure)
        else $error("measure during gain division");

endmodule

### design/gcs_controller.sv
// Controller: accepts items, sequences the gain divider and loads the result register.
module gcs_controller
    import gcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_opcode i_opcode,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_MUL  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.measure   = accept && (i_opcode == OP_MEASURE);
        o_cmd.capture   = accept && (i_opcode == OP_STRETCH);
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    if (i_status.flat || i_status.gain_ok) begin
                        n_state = S_MUL;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result register is full from a load until its transfer.
    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A stretch with a free result register finishes in the next cycle.
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) && slot_free |=> (r_state == S_IDLE) && r_out_valid)
        else $error("stretch result not loaded");

    // The divider only leaves toward the multiply step.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV) || (r_state == S_MUL))
        else $error("divider left to an unexpected state");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten before its transfer");

endmodule

### tb/gray_contrast_stretch_test.sv
// Self-checking testbench for the grayscale min/max contrast stretch block.
module gray_contrast_stretch_test;
    import gcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    gcs_stream_if #(.T(t_in_item))  pix_ch ();
    gcs_stream_if #(.T(t_out_item)) res_ch ();

    gray_contrast_stretch DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    // Tracked extremes of the current frame, as the block should hold them.
    logic [PIX_W-1:0] track_lo;
    logic [PIX_W-1:0] track_hi;

    // Stretched pixels still owed by the block, oldest first.
    t_out_item pending_pixels[$];

    int  error_count;
    int  sent_count;
    int  checked_count;
    int  flat_count;
    int  saturated_count;
    bit  idle_on;

    // Clock with a 2 ns period.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Every mismatch is reported here and counted.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Expected result of stretching one pixel with the tracked extremes.
    function automatic t_out_item stretch_pixel(input logic [PIX_W-1:0] p);
        t_out_item r;
        int        gain;
        int        v;
        r.stretched  = '0;
        r.flat_frame = 1'b0;
        if (track_hi <= track_lo) begin
            r.flat_frame = 1'b1;
        end else if (p > track_lo) begin
            gain = 255 / (int'(track_hi) - int'(track_lo));
            v    = (int'(p) - int'(track_lo)) * gain;
            r.stretched = (v > 255) ? 8'd255 : v[PIX_W-1:0];
        end
        return r;
    endfunction

    // Update the tracked extremes on each accepted input transfer.
    always @(posedge i_clk) begin
        t_in_item it;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        if (!i_rst_n) begin
            track_lo <= 8'd255;
            track_hi <= 8'd0;
        end else if (pix_ch.valid && pix_ch.ready) begin
            it = pix_ch.payload;
            if (it.opcode == OP_MEASURE) begin
                lo = it.first_of_frame ? 8'd255 : track_lo;
                hi = it.first_of_frame ? 8'd0   : track_hi;
                if (it.pixel > hi) hi = it.pixel;
                if (it.pixel < lo) lo = it.pixel;
                track_lo <= lo;
                track_hi <= hi;
            end else begin
                pending_pixels.push_back(stretch_pixel(it.pixel));
            end
        end
    end

    // Compare each result transfer with the oldest pending pixel.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.payload;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result stretched=%0d flat=%0b",
                                          got.stretched, got.flat_frame));
            end else begin
                want = pending_pixels.pop_front();
                checked_count++;
                if (want.flat_frame) flat_count++;
                if (!want.flat_frame && want.stretched == 8'd255) saturated_count++;
                if (got.stretched !== want.stretched)
                    report_mismatch($sformatf("stretched %0d, expected %0d",
                                              got.stretched, want.stretched));
                if (got.flat_frame !== want.flat_frame)
                    report_mismatch($sformatf("flat_frame %0b, expected %0b",
                                              got.flat_frame, want.flat_frame));
            end
        end
    end

    // Result side: random stall bursts while idling is on, otherwise always ready.
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // Present one pixel and hold it until its transfer; called at a falling edge.
    task automatic send_pixel(input t_opcode op, input logic [PIX_W-1:0] p,
                              input logic first);
        t_in_item it;
        it.opcode         = op;
        it.pixel          = p;
        it.first_of_frame = first;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            pix_ch.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        pix_ch.payload = it;
        pix_ch.valid   = 1'b1;
        do @(posedge i_clk); while (!pix_ch.ready);
        @(negedge i_clk);
        pix_ch.valid = 1'b0;
        sent_count++;
    endtask

    // Hold off until every stretched pixel is back, then let the divider settle.
    task automatic wait_for_drain();
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    // Stretch straight out of reset: the held extremes give a flat frame.
    task automatic test_flat_after_reset();
        send_pixel(OP_STRETCH, 8'd0, 1'b1);
        send_pixel(OP_STRETCH, 8'd255, 1'b0);
    endtask

    // Full range frame: gain of one, pixels come back unchanged.
    task automatic test_full_range();
        send_pixel(OP_MEASURE, 8'd128, 1'b1);
        send_pixel(OP_MEASURE, 8'd0, 1'b0);
        send_pixel(OP_MEASURE, 8'd255, 1'b0);
        send_pixel(OP_STRETCH, 8'd0, 1'b0);
        send_pixel(OP_STRETCH, 8'd255, 1'b1);
        send_pixel(OP_STRETCH, 8'd128, 1'b0);
    endtask

    // All measured pixels equal: the frame is flat.
    task automatic test_equal_pixels();
        send_pixel(OP_MEASURE, 8'd77, 1'b1);
        send_pixel(OP_MEASURE, 8'd77, 1'b0);
        send_pixel(OP_STRETCH, 8'd77, 1'b0);
        send_pixel(OP_STRETCH, 8'd0, 1'b0);
    endtask

    // Range of one gives the largest gain; pixels above the range saturate, those below give 0.
    task automatic test_out_of_range();
        send_pixel(OP_MEASURE, 8'd100, 1'b1);
        send_pixel(OP_MEASURE, 8'd101, 1'b0);
        send_pixel(OP_STRETCH, 8'd99, 1'b0);
        send_pixel(OP_STRETCH, 8'd100, 1'b1);
        send_pixel(OP_STRETCH, 8'd101, 1'b0);
        send_pixel(OP_STRETCH, 8'd200, 1'b0);
    endtask

    // A first-of-frame flag in the middle of a measure pass drops earlier pixels.
    task automatic test_restart();
        send_pixel(OP_MEASURE, 8'd10, 1'b1);
        send_pixel(OP_MEASURE, 8'd50, 1'b0);
        send_pixel(OP_MEASURE, 8'd30, 1'b1);
        send_pixel(OP_MEASURE, 8'd40, 1'b0);
        send_pixel(OP_STRETCH, 8'd35, 1'b0);
    endtask

    // One random frame: a measure pass, then a stretch pass over the same pixels.
    task automatic send_random_frame();
        logic [PIX_W-1:0] frame[$];
        int               span;
        int               base;
        int               n;
        logic [PIX_W-1:0] p;
        case ($urandom_range(0, 3))
            0: span = 0;
            1: span = $urandom_range(1, 8);
            2: span = $urandom_range(9, 64);
            default: span = $urandom_range(65, 255);
        endcase
        base = $urandom_range(0, 255 - span);
        n    = $urandom_range(1, 16);
        for (int k = 0; k < n; k++) begin
            p = 8'(base + $urandom_range(0, span));
            frame.push_back(p);
            send_pixel(OP_MEASURE, p, k == 0);
        end
        foreach (frame[k]) begin
            // Now and then a pixel from outside the measured range.
            p = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : frame[k];
            send_pixel(OP_STRETCH, p, 1'($urandom_range(0, 1)));
        end
    endtask

    // Noise: any opcode, pixel and flag.
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_pixel(t_opcode'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
    endtask

    // Mostly well-formed frames with some noise, under random idling.
    task automatic test_random_frames(input int goal);
        bit paused;
        paused = 1'b0;
        while (sent_count < goal) begin
            if ($urandom_range(0, 6) == 0) send_noise();
            else send_random_frame();
            if (!paused && sent_count > goal / 2) begin
                wait_for_drain();
                paused = 1'b1;
            end
        end
    endtask

    // Last stretch of the run at full rate on both sides.
    task automatic test_full_rate(input int goal);
        idle_on = 1'b0;
        while (sent_count < goal) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_random_frame();
        end
    endtask

    // Main sequence.
    initial begin
        int spins;
        error_count     = 0;
        sent_count      = 0;
        checked_count   = 0;
        flat_count      = 0;
        saturated_count = 0;
        idle_on         = 1'b1;
        pix_ch.valid    = 1'b0;
        pix_ch.payload  = '0;
        i_rst_n         = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_flat_after_reset();
        test_full_range();
        test_equal_pixels();
        test_out_of_range();
        test_restart();
        wait_for_drain();
        test_random_frames(1200);
        test_full_rate(1400);

        // Wait for the last results, with a limit.
        spins = 0;
        while (pending_pixels.size() != 0 && spins < 5000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (20) @(negedge i_clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d stretched pixels never arrived",
                                      pending_pixels.size()));

        $display("Covered %0d input pixels and %0d stretched results.",
                 sent_count, checked_count);
        $display("Of those results %0d were flat frames and %0d saturated at full scale.",
                 flat_count, saturated_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #1_000_000;
        $display("Timeout waiting for the block.");
        $display("Some tests failed");
        $finish;
    end

endmodule
